// ===== rtl/dmcht_pkg.sv =====
// shared types and constants for the direct-mapped cache hit tracker
package dmcht_pkg;

  localparam int ADDR_W        = 32;
  localparam int LINE_W        = 10;
  localparam int MAX_LINES     = 1 << LINE_W;
  localparam int CNT_W         = 32;
  localparam int RATE_W        = 17;
  localparam int QUO_W         = 17;
  localparam int NUM_W         = 48;
  localparam int MEMORY_CYCLES = 100;
  localparam int SCALE_W       = 15;
  localparam logic [SCALE_W-1:0] MISS_SCALE = SCALE_W'(MEMORY_CYCLES * 256);
  localparam int TDATA_OUT_W   = 192;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCESS_CYCLES = 2'd2;

  typedef enum logic [1:0] {
    F_CLEAR,
    F_IDLE,
    F_LOOKUP
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_DIV_RATES,
    B_DIV_AMAT,
    B_OUT
  } back_state_t;

  typedef struct packed {
    logic              hit;
    logic [LINE_W-1:0] line_index;
    logic [ADDR_W-1:0] tag_value;
    logic [CNT_W-1:0]  access_count;
    logic [CNT_W-1:0]  hit_count;
    logic [CNT_W-1:0]  miss_count;
  } item_t;

  typedef struct packed {
    item_t             lookup;
    logic [RATE_W-1:0] hit_rate_q16;
    logic [RATE_W-1:0] miss_rate_q16;
    logic [RATE_W-1:0] amat_q8;
  } result_t;

endpackage

// ===== rtl/dmcht_front.sv =====
// lookup front end: tag store, hit/miss classification and counters
module dmcht_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [dmcht_pkg::ADDR_W-1:0] s_tdata,
  input  logic [4:0]                  offset_bits,
  input  logic [3:0]                  index_bits,
  output logic                        push,
  output dmcht_pkg::item_t            push_item,
  input  logic                        full
);
  import dmcht_pkg::*;

  front_state_t state, state_next;

  logic [LINE_W-1:0] clr_addr;
  logic [ADDR_W:0]   mem [MAX_LINES];
  logic [ADDR_W:0]   rd_word;
  logic [LINE_W-1:0] line_r;
  logic [ADDR_W-1:0] tag_r;
  logic [CNT_W-1:0]  acc_cnt, hit_cnt, miss_cnt;
  logic [CNT_W-1:0]  acc_next, hit_next, miss_next;

  logic [ADDR_W-1:0] idx_sh;
  logic [LINE_W-1:0] line_mask, line_in;
  logic [5:0]        tag_sh;
  logic [ADDR_W-1:0] tag_in;
  logic              hit_now, accept, do_push;

  assign idx_sh    = s_tdata >> offset_bits;
  assign line_mask = (index_bits >= 4'd10) ? '1 : LINE_W'((32'd1 << index_bits) - 32'd1);
  assign line_in   = idx_sh[LINE_W-1:0] & line_mask;
  assign tag_sh    = {1'b0, offset_bits} + {2'b00, index_bits};
  assign tag_in    = tag_sh[5] ? '0 : (s_tdata >> tag_sh[4:0]);

  assign hit_now = rd_word[ADDR_W] && (rd_word[ADDR_W-1:0] == tag_r);
  assign accept  = s_tvalid && s_tready;
  assign do_push = (state == F_LOOKUP) && !full;

  assign acc_next  = (acc_cnt == '1) ? acc_cnt : acc_cnt + 1'b1;
  assign hit_next  = (hit_now && hit_cnt != '1) ? hit_cnt + 1'b1 : hit_cnt;
  assign miss_next = (!hit_now && miss_cnt != '1) ? miss_cnt + 1'b1 : miss_cnt;

  // tag store, valid bit on top
  always_ff @(posedge clk) begin
    if (state == F_CLEAR) begin
      mem[clr_addr] <= '0;
    end else if (do_push && !hit_now) begin
      mem[line_r] <= {1'b1, tag_r};
    end
    if (accept) begin
      rd_word <= mem[line_in];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= F_CLEAR;
      clr_addr <= '0;
      acc_cnt  <= '0;
      hit_cnt  <= '0;
      miss_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == F_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (do_push) begin
        acc_cnt  <= acc_next;
        hit_cnt  <= hit_next;
        miss_cnt <= miss_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      line_r <= line_in;
      tag_r  <= tag_in;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_CLEAR:  if (clr_addr == '1) state_next = F_IDLE;
      F_IDLE:   if (accept) state_next = F_LOOKUP;
      F_LOOKUP: if (!full) state_next = F_IDLE;
      default:  state_next = F_CLEAR;
    endcase
  end

  always_comb begin
    s_tready               = (state == F_IDLE);
    push                   = do_push;
    push_item.hit          = hit_now;
    push_item.line_index   = line_r;
    push_item.tag_value    = tag_r;
    push_item.access_count = acc_next;
    push_item.hit_count    = hit_next;
    push_item.miss_count   = miss_next;
  end

endmodule

// ===== rtl/dmcht_fifo.sv =====
// two-entry item queue between lookup and statistics
module dmcht_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  dmcht_pkg::item_t  push_item,
  output logic              full,
  input  logic              pop,
  output dmcht_pkg::item_t  pop_item,
  output logic              empty
);
  import dmcht_pkg::*;

  item_t      entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) wr_ptr <= ~wr_ptr;
      if (pop && !empty) rd_ptr <= ~rd_ptr;
      unique case ({push && !full, pop && !empty})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/dmcht_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle
module dmcht_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [dmcht_pkg::NUM_W-1:0]  dividend,
  input  logic [dmcht_pkg::CNT_W-1:0]  divisor,
  output logic                         busy,
  output logic [dmcht_pkg::QUO_W-1:0]  quotient
);
  import dmcht_pkg::*;

  logic [CNT_W-1:0] rem, rem_next, dvs;
  logic [QUO_W-1:0] num;
  logic [4:0]       step;
  logic [CNT_W:0]   trial;
  logic [CNT_W+1:0] diff;
  logic             qbit;

  // dividend high part is below the divisor, so the quotient fits QUO_W bits
  assign trial    = {rem, num[QUO_W-1]};
  assign diff     = {1'b0, trial} - {2'b00, dvs};
  assign qbit     = !diff[CNT_W+1];
  assign rem_next = qbit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
  assign quotient = num;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == 5'(QUO_W - 1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= CNT_W'(dividend[NUM_W-1:QUO_W]);
      num <= dividend[QUO_W-1:0];
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      num <= {num[QUO_W-2:0], qbit};
    end
  end

endmodule

// ===== rtl/dmcht_back.sv =====
// statistics back end: rate and amat division, output register
module dmcht_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        empty,
  output logic                        pop,
  input  dmcht_pkg::item_t            pop_item,
  input  logic [7:0]                  access_cycles,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output dmcht_pkg::result_t          m_result
);
  import dmcht_pkg::*;

  back_state_t state, state_next;

  item_t                    cur;
  logic [NUM_W-1:0]         amat_num;
  logic [RATE_W-1:0]        hr_q, mr_q;
  logic                     start0, start1, busy0, busy1;
  logic [NUM_W-1:0]         num0, num1;
  logic [QUO_W-1:0]         quo0, quo1;
  logic                     out_free, load_out;

  assign out_free = !m_tvalid || m_tready;
  assign load_out = (state == B_OUT) && out_free;

  dmcht_div u_div0 (
    .clk(clk), .rst(rst), .start(start0), .dividend(num0),
    .divisor(cur.access_count), .busy(busy0), .quotient(quo0)
  );

  dmcht_div u_div1 (
    .clk(clk), .rst(rst), .start(start1), .dividend(num1),
    .divisor(cur.access_count), .busy(busy1), .quotient(quo1)
  );

  always_ff @(posedge clk) begin
    if (pop) cur <= pop_item;
    if (state == B_MUL) amat_num <= NUM_W'(cur.miss_count) * NUM_W'(MISS_SCALE);
    if (state == B_DIV_RATES && !busy0 && !busy1) begin
      hr_q <= quo0;
      mr_q <= quo1;
    end
    if (load_out) begin
      m_result.lookup        <= cur;
      m_result.hit_rate_q16  <= hr_q;
      m_result.miss_rate_q16 <= mr_q;
      m_result.amat_q8       <= RATE_W'({access_cycles, 8'd0}) + quo0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:      if (!empty) state_next = B_MUL;
      B_MUL:       state_next = B_DIV_RATES;
      B_DIV_RATES: if (!busy0 && !busy1) state_next = B_DIV_AMAT;
      B_DIV_AMAT:  if (!busy0) state_next = B_OUT;
      B_OUT:       if (out_free) state_next = B_IDLE;
      default:     state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop    = (state == B_IDLE) && !empty;
    start0 = 1'b0;
    start1 = 1'b0;
    num0   = {cur.hit_count, 16'd0};
    num1   = {cur.miss_count, 16'd0};
    unique case (state)
      B_MUL: begin
        start0 = 1'b1;
        start1 = 1'b1;
      end
      B_DIV_RATES: begin
        num0   = amat_num;
        start0 = !busy0 && !busy1;
      end
      default: begin
        start0 = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/direct_mapped_cache_hit_tracker_top.sv =====
// top level of the direct-mapped cache hit tracker
// Each item carries one byte address. The front end takes an item only while
// idle and takes no new one before the last is pushed: it reads the 1024-line
// tag store, then compares, installs the tag on a miss and updates the
// saturating counters, waiting there while the queue is full. After reset the
// front end first clears the valid bits of all 1024 lines, one line per cycle,
// and takes no item during that pass. A two-entry queue feeds the statistics
// back end, which takes one item from the queue, forms the product for the
// amat term, then makes two passes of 17 quotient steps through a bit-per-cycle
// divider (hit and miss rate in parallel, then the amat quotient), then loads the
// output register; it takes the next item only after that load.
module direct_mapped_cache_hit_tracker_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [31:0]                          s_tdata,  // address
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // hit, line_index, tag_value, access_count, hit_count, miss_count,
  // hit_rate_q16, miss_rate_q16, amat_q8, zero fill
  output logic [dmcht_pkg::TDATA_OUT_W-1:0]   m_tdata,
  input  logic                                 cfg_we,
  input  logic [dmcht_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [7:0]                           cfg_data
);
  import dmcht_pkg::*;

  logic [4:0] offset_bits;
  logic [3:0] index_bits;
  logic [7:0] access_cycles;

  logic    push, full, pop, empty;
  item_t   push_item, pop_item;
  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits   <= 5'd4;
      index_bits    <= 4'd6;
      access_cycles <= 8'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OFFSET_BITS:   offset_bits   <= cfg_data[4:0];
        CFG_INDEX_BITS:    index_bits    <= cfg_data[3:0];
        CFG_ACCESS_CYCLES: access_cycles <= cfg_data;
        default:           access_cycles <= access_cycles;
      endcase
    end
  end

  dmcht_front u_front (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .offset_bits(offset_bits), .index_bits(index_bits),
    .push(push), .push_item(push_item), .full(full)
  );

  dmcht_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .push_item(push_item), .full(full),
    .pop(pop), .pop_item(pop_item), .empty(empty)
  );

  dmcht_back u_back (
    .clk(clk), .rst(rst), .empty(empty), .pop(pop), .pop_item(pop_item),
    .access_cycles(access_cycles), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_result(res)
  );

  assign m_tdata = {2'b00, res.amat_q8, res.miss_rate_q16, res.hit_rate_q16,
                    res.lookup.miss_count, res.lookup.hit_count,
                    res.lookup.access_count, res.lookup.tag_value,
                    res.lookup.line_index, res.lookup.hit};

endmodule

// ===== rtl/dmcht_checker.sv =====
// port-level checks for the cache hit tracker, bound to the top level
module dmcht_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [dmcht_pkg::TDATA_OUT_W-1:0] m_tdata
);
  import dmcht_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[74:43] != 32'd0)
    else $error("result with zero access count");

  a_counts_bounded: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[106:75] <= m_tdata[74:43] && m_tdata[138:107] <= m_tdata[74:43])
    else $error("hit or miss count above access count");

  a_rate_bounded: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[155:139] <= 17'h10000 && m_tdata[172:156] <= 17'h10000)
    else $error("rate above one");

endmodule

bind direct_mapped_cache_hit_tracker_top dmcht_checker u_dmcht_checker (
  .clk(clk), .rst(rst), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
